[rtl/aps_pkg.sv]
// shared types and constants for the box physics step block
package aps_pkg;

    localparam int MAX_ENTRIES   = 64;
    localparam int IDX_W         = $clog2(MAX_ENTRIES);
    localparam int FRACTION_BITS = 8;
    localparam int VAL_W         = 24;
    localparam int SIZE_W        = 23;
    localparam int DT_W          = 16;
    localparam int CNT_W         = 7;
    localparam int KEEP_FACTOR   = 65208;
    localparam int KEEP_SHIFT    = 16;
    localparam int ROW_W         = 2 * VAL_W + 2 * SIZE_W;
    localparam int VEL_W         = 2 * VAL_W + 1;

    localparam logic [1:0] CFG_GRAVITY_X = 2'd0;
    localparam logic [1:0] CFG_GRAVITY_Y = 2'd1;
    localparam logic [1:0] CFG_ENTRIES   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_LATCH, ST_GRAV, ST_FRIC, ST_MOVE,
        ST_SCAN_RD, ST_SCAN_CMP, ST_RESOLVE, ST_FINISH, ST_OUT
    } aps_state_t;

    // controller to datapath
    typedef struct packed {
        logic       capture;   // take input beat
        logic       write_load;
        logic       latch_row;
        logic       do_grav;
        logic       do_fric;
        logic       do_move;   // form trial position for current axis
        logic       scan_rd;   // issue read of scan entry
        logic       scan_cmp;  // compare scan entry
        logic       resolve;   // undo or keep trial
        logic       finish;    // threshold and write back
        logic       axis;      // 0 x, 1 y
    } aps_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_load;
        logic is_static;
        logic scan_done;
    } aps_stat_t;

    function automatic logic signed [VAL_W-1:0] sat(input logic signed [63:0] v);
        if (v > 64'sd8388607) return 24'sh7fffff;
        if (v < -64'sd8388608) return 24'sh800000;
        return v[VAL_W-1:0];
    endfunction

    function automatic logic signed [63:0] rshift(input logic signed [63:0] p,
                                                  input int s);
        logic [63:0] m;
        m = p[63] ? (64'd0 - p) : p;
        m = (m + (64'd1 << (s - 1))) >> s;
        return p[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

[rtl/aps_ram.sv]
// generic single port write, single port registered read memory
module aps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/aps_ctrl.sv]
// sequencer for load and advance items
module aps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  aps_pkg::aps_stat_t stat,
    output aps_pkg::aps_cmd_t  cmd
);
    import aps_pkg::*;

    aps_state_t state_reg, state_next;
    logic       axis_reg, axis_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_READ;
            ST_READ:     state_next = stat.is_load ? ST_OUT : ST_LATCH;
            ST_LATCH:    state_next = stat.is_static ? ST_OUT : ST_GRAV;
            ST_GRAV:     state_next = ST_FRIC;
            ST_FRIC: begin
                state_next = ST_MOVE;
                axis_next  = 1'b0;
            end
            ST_MOVE:     state_next = ST_SCAN_RD;
            ST_SCAN_RD:  state_next = stat.scan_done ? ST_RESOLVE : ST_SCAN_CMP;
            ST_SCAN_CMP: state_next = ST_SCAN_RD;
            ST_RESOLVE: begin
                if (axis_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_MOVE;
                    axis_next  = 1'b1;
                end
            end
            ST_FINISH:   state_next = ST_OUT;
            ST_OUT:      if (m_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd            = '0;
        cmd.axis       = axis_reg;
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_READ:     cmd.write_load = stat.is_load;
            ST_LATCH:    cmd.latch_row  = 1'b1;
            ST_GRAV:     cmd.do_grav    = 1'b1;
            ST_FRIC:     cmd.do_fric    = 1'b1;
            ST_MOVE:     cmd.do_move    = 1'b1;
            ST_SCAN_RD:  cmd.scan_rd    = 1'b1;
            ST_SCAN_CMP: cmd.scan_cmp   = 1'b1;
            ST_RESOLVE:  cmd.resolve    = 1'b1;
            ST_FINISH:   cmd.finish     = 1'b1;
            ST_OUT:      m_valid        = 1'b1;
            default: ;
        endcase
    end
endmodule

[rtl/aps_dp.sv]
// entry tables, velocity arithmetic and overlap scan
module aps_dp (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  aps_pkg::aps_cmd_t                        cmd,
    output aps_pkg::aps_stat_t                       stat,
    input  logic                                     cfg_valid,
    input  logic [1:0]                               cfg_index,
    input  logic [aps_pkg::VAL_W-1:0]                cfg_data,
    input  logic                                     s_action,
    input  logic [aps_pkg::IDX_W-1:0]                s_entry_index,
    input  logic signed [aps_pkg::VAL_W-1:0]         s_load_pos_x,
    input  logic signed [aps_pkg::VAL_W-1:0]         s_load_pos_y,
    input  logic [aps_pkg::SIZE_W-1:0]               s_load_width,
    input  logic [aps_pkg::SIZE_W-1:0]               s_load_height,
    input  logic signed [aps_pkg::VAL_W-1:0]         s_load_vel_x,
    input  logic signed [aps_pkg::VAL_W-1:0]         s_load_vel_y,
    input  logic                                     s_load_static,
    input  logic [aps_pkg::DT_W-1:0]                 s_time_step,
    output logic [aps_pkg::IDX_W-1:0]                m_out_index,
    output logic signed [aps_pkg::VAL_W-1:0]         m_new_pos_x,
    output logic signed [aps_pkg::VAL_W-1:0]         m_new_pos_y,
    output logic signed [aps_pkg::VAL_W-1:0]         m_new_vel_x,
    output logic signed [aps_pkg::VAL_W-1:0]         m_new_vel_y,
    output logic                                     m_blocked_x,
    output logic                                     m_blocked_y
);
    import aps_pkg::*;

    localparam logic signed [VAL_W-1:0] HALF = VAL_W'(1 << (FRACTION_BITS - 1));

    // configuration registers
    logic signed [VAL_W-1:0] grav_x_reg, grav_y_reg;
    logic [CNT_W-1:0]        n_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_x_reg <= '0;
            grav_y_reg <= '0;
            n_use_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GRAVITY_X: grav_x_reg <= cfg_data;
                CFG_GRAVITY_Y: grav_y_reg <= cfg_data;
                CFG_ENTRIES:   n_use_reg  <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // captured input beat
    logic                    act_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [VAL_W-1:0] lpx_reg, lpy_reg, lvx_reg, lvy_reg;
    logic [SIZE_W-1:0]       lw_reg, lh_reg;
    logic                    lst_reg;
    logic [DT_W-1:0]         dt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg <= s_action;
            idx_reg <= s_entry_index;
            lpx_reg <= s_load_pos_x;
            lpy_reg <= s_load_pos_y;
            lw_reg  <= s_load_width;
            lh_reg  <= s_load_height;
            lvx_reg <= s_load_vel_x;
            lvy_reg <= s_load_vel_y;
            lst_reg <= s_load_static;
            dt_reg  <= s_time_step;
        end
    end

    // working copy of the advanced entry
    logic signed [VAL_W-1:0] px_reg, py_reg, vx_reg, vy_reg, old_reg;
    logic [SIZE_W-1:0]       w_reg, h_reg;
    logic                    st_reg, bx_reg, by_reg, hit_reg;
    logic [CNT_W-1:0]        scan_reg;
    logic signed [VAL_W-1:0] vx_fin, vy_fin;

    // memories: geometry row and velocity row
    logic [ROW_W-1:0] row_wdata, row_rdata;
    logic [VEL_W-1:0] vel_wdata, vel_rdata;
    logic             row_we, vel_we;
    logic [IDX_W-1:0] row_raddr;
    logic [CNT_W-1:0] n_eff;

    assign n_eff = (n_use_reg > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : n_use_reg;

    always_comb begin
        row_we    = cmd.write_load || cmd.finish;
        vel_we    = row_we;
        if (cmd.write_load) begin
            row_wdata = {lpx_reg, lpy_reg, lw_reg, lh_reg};
            vel_wdata = {lvx_reg, lvy_reg, lst_reg};
        end else begin
            row_wdata = {px_reg, py_reg, w_reg, h_reg};
            vel_wdata = {vx_fin, vy_fin, st_reg};
        end
        row_raddr = cmd.scan_rd ? scan_reg[IDX_W-1:0] : idx_reg;
    end

    aps_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ENTRIES)) u_row_ram (
        .aclk(aclk), .we(row_we), .waddr(idx_reg), .wdata(row_wdata),
        .raddr(row_raddr), .rdata(row_rdata)
    );

    aps_ram #(.WIDTH(VEL_W), .DEPTH(MAX_ENTRIES)) u_vel_ram (
        .aclk(aclk), .we(vel_we), .waddr(idx_reg), .wdata(vel_wdata),
        .raddr(idx_reg), .rdata(vel_rdata)
    );

    // scan entry fields
    logic signed [VAL_W-1:0] ox, oy;
    logic [SIZE_W-1:0]       ow, oh;
    logic                    overlap;
    logic [IDX_W-1:0]        cmp_idx_reg;
    assign {ox, oy, ow, oh} = row_rdata;

    always_comb begin
        overlap = ($signed({px_reg[VAL_W-1], px_reg}) < $signed({ox[VAL_W-1], ox}) + $signed({2'b0, ow}))
               && ($signed({px_reg[VAL_W-1], px_reg}) + $signed({2'b0, w_reg}) > $signed({ox[VAL_W-1], ox}))
               && ($signed({py_reg[VAL_W-1], py_reg}) < $signed({oy[VAL_W-1], oy}) + $signed({2'b0, oh}))
               && ($signed({py_reg[VAL_W-1], py_reg}) + $signed({2'b0, h_reg}) > $signed({oy[VAL_W-1], oy}));
    end

    // combinational arithmetic terms for gravity, friction and move
    logic signed [63:0] gprod, fprod, mprod;
    always_comb begin
        gprod = 64'(grav_x_reg) * $signed({48'd0, dt_reg});
        fprod = 64'(vx_reg) * 64'sd65208;
        mprod = 64'(cmd.axis ? vy_reg : vx_reg) * $signed({48'd0, dt_reg});
        vx_fin = (vx_reg > -HALF && vx_reg < HALF) ? '0 : vx_reg;
        vy_fin = (vy_reg > -HALF && vy_reg < HALF) ? '0 : vy_reg;
    end

    logic signed [63:0] gyprod, fyprod;
    assign gyprod = 64'(grav_y_reg) * $signed({48'd0, dt_reg});
    assign fyprod = 64'(vy_reg) * 64'sd65208;

    always_ff @(posedge aclk) begin
        if (cmd.latch_row) begin
            {px_reg, py_reg, w_reg, h_reg} <= row_rdata;
            {vx_reg, vy_reg, st_reg}       <= vel_rdata;
            bx_reg <= 1'b0;
            by_reg <= 1'b0;
        end
        if (cmd.do_grav) begin
            vx_reg <= sat(64'(vx_reg) + rshift(gprod, FRACTION_BITS));
            vy_reg <= sat(64'(vy_reg) + rshift(gyprod, FRACTION_BITS));
        end
        if (cmd.do_fric) begin
            vx_reg <= sat(rshift(fprod, KEEP_SHIFT));
            vy_reg <= sat(rshift(fyprod, KEEP_SHIFT));
        end
        if (cmd.do_move) begin
            hit_reg  <= 1'b0;
            scan_reg <= '0;
            if (cmd.axis) begin
                old_reg <= py_reg;
                py_reg  <= sat(64'(py_reg) + rshift(mprod, FRACTION_BITS));
            end else begin
                old_reg <= px_reg;
                px_reg  <= sat(64'(px_reg) + rshift(mprod, FRACTION_BITS));
            end
        end
        if (cmd.scan_rd && !(scan_reg >= n_eff)) begin
            cmp_idx_reg <= scan_reg[IDX_W-1:0];
            scan_reg    <= scan_reg + 1'b1;
        end
        if (cmd.scan_cmp && cmp_idx_reg != idx_reg && overlap) begin
            hit_reg <= 1'b1;
        end
        if (cmd.resolve && hit_reg) begin
            if (cmd.axis) begin
                py_reg <= old_reg;
                vy_reg <= sat(-64'(vy_reg));
                by_reg <= 1'b1;
            end else begin
                px_reg <= old_reg;
                vx_reg <= sat(-64'(vx_reg));
                bx_reg <= 1'b1;
            end
        end
        if (cmd.finish) begin
            vx_reg <= vx_fin;
            vy_reg <= vy_fin;
        end
        if (cmd.write_load) begin
            px_reg <= lpx_reg;
            py_reg <= lpy_reg;
            vx_reg <= lvx_reg;
            vy_reg <= lvy_reg;
            bx_reg <= 1'b0;
            by_reg <= 1'b0;
        end
    end

    assign stat.is_load   = !act_reg;
    assign stat.is_static = vel_rdata[0];
    assign stat.scan_done = (scan_reg >= n_eff);

    // result fields
    assign m_out_index = idx_reg;
    assign m_new_pos_x = px_reg;
    assign m_new_pos_y = py_reg;
    assign m_new_vel_x = vx_reg;
    assign m_new_vel_y = vy_reg;
    assign m_blocked_x = bx_reg;
    assign m_blocked_y = by_reg;
endmodule

[rtl/aabb_physics_step.sv]
// top level of the box physics step block
//
// channel  | ports                        | direction
// ---------+------------------------------+----------
// input    | s_valid, s_ready, s_*        | in
// result   | m_valid, m_ready, m_*        | out
// config   | cfg_valid, cfg_ready, cfg_*  | in
//
// a load runs idle, read and output; a static advance adds latch; an advance also runs
// gravity, friction, move/scan/resolve per axis, finish (entries_in_use capped at 64)
// the overlap scan reads each table entry and then compares it, once for each axis
// one item at a time; the result holds until m_ready, then input opens again
// synchronous active low reset clears the controller and config registers, not tables
module aabb_physics_step (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [aps_pkg::VAL_W-1:0]          cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [aps_pkg::IDX_W-1:0]          s_entry_index,
    input  logic signed [aps_pkg::VAL_W-1:0]   s_load_pos_x,
    input  logic signed [aps_pkg::VAL_W-1:0]   s_load_pos_y,
    input  logic [aps_pkg::SIZE_W-1:0]         s_load_width,
    input  logic [aps_pkg::SIZE_W-1:0]         s_load_height,
    input  logic signed [aps_pkg::VAL_W-1:0]   s_load_vel_x,
    input  logic signed [aps_pkg::VAL_W-1:0]   s_load_vel_y,
    input  logic                               s_load_static,
    input  logic [aps_pkg::DT_W-1:0]           s_time_step,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [aps_pkg::IDX_W-1:0]          m_out_index,
    output logic signed [aps_pkg::VAL_W-1:0]   m_new_pos_x,
    output logic signed [aps_pkg::VAL_W-1:0]   m_new_pos_y,
    output logic signed [aps_pkg::VAL_W-1:0]   m_new_vel_x,
    output logic signed [aps_pkg::VAL_W-1:0]   m_new_vel_y,
    output logic                               m_blocked_x,
    output logic                               m_blocked_y
);
    import aps_pkg::*;

    aps_cmd_t  cmd;
    aps_stat_t stat;

    assign cfg_ready = 1'b1;

    aps_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    aps_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_action(s_action), .s_entry_index(s_entry_index),
        .s_load_pos_x(s_load_pos_x), .s_load_pos_y(s_load_pos_y),
        .s_load_width(s_load_width), .s_load_height(s_load_height),
        .s_load_vel_x(s_load_vel_x), .s_load_vel_y(s_load_vel_y),
        .s_load_static(s_load_static), .s_time_step(s_time_step),
        .m_out_index(m_out_index), .m_new_pos_x(m_new_pos_x),
        .m_new_pos_y(m_new_pos_y), .m_new_vel_x(m_new_vel_x),
        .m_new_vel_y(m_new_vel_y), .m_blocked_x(m_blocked_x),
        .m_blocked_y(m_blocked_y)
    );
endmodule
